[src/stt_pkg.sv]
// ============================================================================
// stt_pkg: shared types and constants for the satellite tracking table
// Actions, constellation codes, the entry record and the command record that
// travels from the front queue to the execution engine.
// ============================================================================
package stt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;
  localparam int unsigned MAX_RESULTS     = 32;
  localparam logic [31:0] TIMEOUT_RST     = 32'd15000;
  localparam int unsigned CMDQ_DEPTH      = 2;

  localparam logic [2:0] ACT_SEEN   = 3'd0;
  localparam logic [2:0] ACT_CLEAR  = 3'd1;
  localparam logic [2:0] ACT_MARK   = 3'd2;
  localparam logic [2:0] ACT_PRUNE  = 3'd3;
  localparam logic [2:0] ACT_REPORT = 3'd4;

  localparam logic [2:0] CON_UNKNOWN = 3'd0;
  localparam logic [2:0] CON_MIXED   = 3'd7;

  typedef enum logic [1:0] {
    OP_SEEN,
    OP_CLEAR,
    OP_MARK,
    OP_OTHER
  } op_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] con;
    logic [7:0] id;
    logic [7:0] sig;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  con;
    logic [7:0]  id;
    logic [7:0]  sig;
    logic        used;
    logic        tracked;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] con;
    logic [7:0] id;
    logic [7:0] sig;
    logic       used;
    logic       tracked;
    logic [5:0] count;
    logic       last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_PRUNE,
    ST_PRUNE_WR,
    ST_RPT_FIND,
    ST_RPT_EMIT,
    ST_STATUS
  } eng_state_t;

endpackage

[src/stt_front.sv]
// ============================================================================
// stt_front: input queue
// Accepts items and holds them in a short queue ahead of the engine.
// ============================================================================
module stt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  stt_pkg::cmd_t push_cmd,
  output logic          cmd_valid,
  output stt_pkg::cmd_t cmd,
  input  logic          cmd_take
);
  localparam int unsigned D = stt_pkg::CMDQ_DEPTH;
  localparam int unsigned AW = $clog2(D);

  stt_pkg::cmd_t   mem_r [D];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            wr, rd;

  assign full      = (cnt_r == (AW+1)'(D));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = mem_r[rp_r];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= push_cmd;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

[src/stt_engine.sv]
// ============================================================================
// stt_engine: table engine
// Executes one command at a time over the entry table, scanning one entry a
// cycle, and emits results into a one-entry output register.
// ============================================================================
module stt_engine #(
  parameter int unsigned MAX_ENTRIES = stt_pkg::MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      timeout,
  input  logic             cmd_valid,
  input  stt_pkg::cmd_t    cmd,
  output logic             cmd_take,
  output logic             res_valid,
  output stt_pkg::result_t res,
  input  logic             res_take
);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  stt_pkg::entry_t   tbl_r [MAX_ENTRIES];
  stt_pkg::eng_state_t st_r, st_nxt;
  stt_pkg::cmd_t     c_r;
  logic [CW-1:0]     cnt_r, i_r, w_r, emitted_r;
  logic [IW-1:0]     tgt_r, old_r, best_r;
  logic              found_r, best_ok_r;
  logic [MAX_ENTRIES-1:0] done_r;
  logic              res_valid_r;
  stt_pkg::result_t  res_r;
  stt_pkg::entry_t   e, be;
  logic [IW-1:0]     ix;
  logic              in_range, hit, better, out_free, stale;
  logic [5:0]        cnt6;
  logic              any;

  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign out_free  = !res_valid_r || res_take;
  assign ix        = i_r[IW-1:0];
  assign in_range  = (i_r < cnt_r);
  assign e         = tbl_r[ix];
  assign be        = tbl_r[best_r];
  assign cnt6      = (32'(cnt_r) > 32'd63) ? 6'd63 : 6'(cnt_r);
  assign any       = (c_r.con == stt_pkg::CON_MIXED) || (c_r.con == stt_pkg::CON_UNKNOWN);
  assign stale     = ((c_r.now - e.seen) > timeout);

  always_comb begin
    hit = 1'b0;
    case (c_r.action)
      stt_pkg::ACT_SEEN: hit = (e.id == c_r.id) &&
                               ((e.con == c_r.con) || (c_r.con == stt_pkg::CON_MIXED));
      stt_pkg::ACT_MARK: hit = (e.id == c_r.id) && (any || (e.con == c_r.con));
      default:           hit = 1'b0;
    endcase
  end

  always_comb begin
    if (!best_ok_r) better = 1'b1;
    else if (e.sig != be.sig) better = e.sig > be.sig;
    else better = e.id < be.id;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      stt_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.action)
            stt_pkg::ACT_SEEN, stt_pkg::ACT_CLEAR,
            stt_pkg::ACT_MARK:   st_nxt = stt_pkg::ST_SCAN;
            stt_pkg::ACT_PRUNE:  st_nxt = stt_pkg::ST_PRUNE;
            stt_pkg::ACT_REPORT: st_nxt = stt_pkg::ST_RPT_FIND;
            default:             st_nxt = stt_pkg::ST_STATUS;
          endcase
        end
      end
      stt_pkg::ST_SCAN: begin
        if (!in_range || (hit && c_r.action != stt_pkg::ACT_CLEAR))
          st_nxt = stt_pkg::ST_WRITE;
      end
      stt_pkg::ST_WRITE:    st_nxt = stt_pkg::ST_STATUS;
      stt_pkg::ST_PRUNE:    if (!in_range) st_nxt = stt_pkg::ST_PRUNE_WR;
      stt_pkg::ST_PRUNE_WR: st_nxt = stt_pkg::ST_STATUS;
      stt_pkg::ST_RPT_FIND: begin
        if (cnt_r == '0) st_nxt = stt_pkg::ST_STATUS;
        else if (!in_range) st_nxt = stt_pkg::ST_RPT_EMIT;
      end
      stt_pkg::ST_RPT_EMIT: begin
        if (out_free) begin
          if (emitted_r + 1'b1 == cnt_r || emitted_r + 1'b1 == CW'(stt_pkg::MAX_RESULTS))
            st_nxt = stt_pkg::ST_IDLE;
          else st_nxt = stt_pkg::ST_RPT_FIND;
        end
      end
      stt_pkg::ST_STATUS: if (out_free) st_nxt = stt_pkg::ST_IDLE;
      default: st_nxt = stt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = (st_r == stt_pkg::ST_IDLE) && cmd_valid;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      stt_pkg::ST_IDLE: begin
        c_r <= cmd;
        i_r <= '0;
        w_r <= '0;
        found_r <= 1'b0;
        old_r <= '0;
        best_ok_r <= 1'b0;
        emitted_r <= '0;
        done_r <= '0;
      end
      stt_pkg::ST_SCAN: begin
        if (in_range) begin
          if (c_r.action == stt_pkg::ACT_CLEAR) begin
            if (any || e.con == c_r.con) tbl_r[ix].used <= 1'b0;
          end else if (hit) begin
            found_r <= 1'b1;
            tgt_r <= ix;
          end
          if (e.seen < tbl_r[old_r].seen) old_r <= ix;
          i_r <= i_r + 1'b1;
        end
      end
      stt_pkg::ST_WRITE: begin
        if (c_r.action == stt_pkg::ACT_SEEN) begin
          if (found_r) begin
            if (c_r.con != stt_pkg::CON_MIXED) tbl_r[tgt_r].con <= c_r.con;
            tbl_r[tgt_r].sig <= c_r.sig;
            tbl_r[tgt_r].tracked <= (c_r.sig != 8'd0);
            tbl_r[tgt_r].seen <= c_r.now;
          end else begin
            tbl_r[(cnt_r == CW'(MAX_ENTRIES)) ? old_r : cnt_r[IW-1:0]] <=
              '{con: c_r.con, id: c_r.id, sig: c_r.sig, used: 1'b0,
                tracked: (c_r.sig != 8'd0), seen: c_r.now};
          end
        end else if (c_r.action == stt_pkg::ACT_MARK && found_r) begin
          tbl_r[tgt_r].used <= 1'b1;
          tbl_r[tgt_r].tracked <= 1'b1;
          tbl_r[tgt_r].seen <= c_r.now;
        end
      end
      stt_pkg::ST_PRUNE: begin
        if (in_range) begin
          if (!stale) begin
            tbl_r[w_r[IW-1:0]] <= e;
            w_r <= w_r + 1'b1;
          end
          i_r <= i_r + 1'b1;
        end
      end
      stt_pkg::ST_RPT_FIND: begin
        if (in_range) begin
          if (!done_r[ix] && better) begin
            best_r <= ix;
            best_ok_r <= 1'b1;
          end
          i_r <= i_r + 1'b1;
        end
      end
      stt_pkg::ST_RPT_EMIT: begin
        if (out_free) begin
          done_r[best_r] <= 1'b1;
          emitted_r <= emitted_r + 1'b1;
          best_ok_r <= 1'b0;
          i_r <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= stt_pkg::ST_IDLE;
      cnt_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (res_take) res_valid_r <= 1'b0;
      if (st_r == stt_pkg::ST_WRITE && c_r.action == stt_pkg::ACT_SEEN &&
          !found_r && cnt_r != CW'(MAX_ENTRIES))
        cnt_r <= cnt_r + 1'b1;
      if (st_r == stt_pkg::ST_PRUNE_WR) cnt_r <= w_r;
      if (st_r == stt_pkg::ST_STATUS && out_free) begin
        res_valid_r <= 1'b1;
        res_r <= '{valid: 1'b0, con: 3'd0, id: 8'd0, sig: 8'd0, used: 1'b0,
                   tracked: 1'b0, count: cnt6, last: 1'b1};
      end
      if (st_r == stt_pkg::ST_RPT_EMIT && out_free) begin
        res_valid_r <= 1'b1;
        res_r <= '{valid: 1'b1, con: be.con, id: be.id, sig: be.sig, used: be.used,
                   tracked: be.tracked, count: cnt6,
                   last: (emitted_r + 1'b1 == cnt_r) ||
                         (emitted_r + 1'b1 == CW'(stt_pkg::MAX_RESULTS))};
      end
    end
  end
endmodule

[src/satellite_tracking_table_top.sv]
// ============================================================================
// satellite_tracking_table_top: satellite tracking table
// Ordered table of satellite entries with seen, clear, mark, prune and sorted
// report actions.
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  input   | in_*                          | push / full
//  result  | out_*                         | empty / pop
//  config  | cfg_we, cfg_data              | write enable, no wait
//
//  Seen, clear, mark: one entry scanned per cycle (N live).
//  Prune: one scan over the table. Report: a full scan per entry.
//  A two-item queue decouples input from the engine; one output register.
//  Reset clears the table count; timeout resets to 15000.
// ============================================================================
module satellite_tracking_table_top #(
  parameter int unsigned MAX_ENTRIES = stt_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_constellation,
  input  logic [7:0]  in_sat_id,
  input  logic [7:0]  in_signal_level,
  input  logic [31:0] in_now_ms,
  output logic        empty,
  input  logic        pop,
  output logic        out_entry_valid,
  output logic [2:0]  out_entry_constellation,
  output logic [7:0]  out_entry_id,
  output logic [7:0]  out_entry_signal,
  output logic        out_entry_used,
  output logic        out_entry_tracked,
  output logic [5:0]  out_table_count,
  output logic        out_last
);
  logic [31:0]      timeout_r;
  stt_pkg::cmd_t    push_cmd, cmd;
  logic             cmd_valid, cmd_take, res_valid;
  stt_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) timeout_r <= stt_pkg::TIMEOUT_RST;
    else if (cfg_we) timeout_r <= cfg_data;
  end

  assign push_cmd = '{action: in_action, con: in_constellation, id: in_sat_id,
                      sig: in_signal_level, now: in_now_ms};

  stt_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .push_cmd(push_cmd),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  stt_engine #(.MAX_ENTRIES(MAX_ENTRIES)) u_engine (
    .clk(clk), .rst_n(rst_n), .timeout(timeout_r), .cmd_valid(cmd_valid),
    .cmd(cmd), .cmd_take(cmd_take), .res_valid(res_valid), .res(res),
    .res_take(pop)
  );

  assign empty                   = !res_valid;
  assign out_entry_valid         = res.valid;
  assign out_entry_constellation = res.con;
  assign out_entry_id            = res.id;
  assign out_entry_signal        = res.sig;
  assign out_entry_used          = res.used;
  assign out_entry_tracked       = res.tracked;
  assign out_table_count         = res.count;
  assign out_last                = res.last;
endmodule
